@@ sv/ipac_pkg.sv @@
package ipac_pkg;

    localparam int SENSOR_COUNT   = 6;
    localparam int SAMPLE_BITS    = 12;
    localparam int SENSOR_IDX_W   = 3;
    localparam int CHANNEL_W      = 4;
    localparam int CHANNEL_OFFSET = 3;

    typedef enum logic [0:0] {
        CMD_TICK = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                    command;
        logic [SAMPLE_BITS-1:0]  sample_first;
        logic [SAMPLE_BITS-1:0]  sample_second;
        logic [SENSOR_IDX_W-1:0] sensor_select;
    } in_t;

    typedef struct packed {
        logic [SENSOR_COUNT-1:0] emitter_mask;
        logic [CHANNEL_W-1:0]    adc_channel;
        logic [SAMPLE_BITS-1:0]  ambient_level;
        logic [SAMPLE_BITS-1:0]  reflected_level;
    } out_t;

endpackage

@@ sv/ir_proximity_ambient_cancel_scanner_core.sv @@
// A result is registered into the head entry, or into the skid entry when the head is held, before it is presented.
// Throughput: one beat per cycle while the skid entry is empty; a two-entry output buffer (result + skid)
// keeps s_ready high while one finished result waits on m_ready.
// Reset (aresetn low, synchronous): dark phase, scan index 0, all ambient,
// lit and reflected stores zero, output buffer empty.
module ir_proximity_ambient_cancel_scanner_core
    import ipac_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic                    lit_phase_reg, lit_phase_next;
    logic [SENSOR_IDX_W-1:0] scan_index_reg, scan_index_next;
    logic [SAMPLE_BITS-1:0]  ambient_reg   [SENSOR_COUNT];
    logic [SAMPLE_BITS-1:0]  lit_reg       [SENSOR_COUNT];
    logic [SAMPLE_BITS-1:0]  reflected_reg [SENSOR_COUNT];

    out_t head_reg, skid_reg;
    logic head_valid_reg, skid_valid_reg;

    logic                   push, pop;
    logic                   is_tick, sel_ok;
    logic [SAMPLE_BITS:0]   sum;
    logic [SAMPLE_BITS-1:0] avg;
    logic [SAMPLE_BITS-1:0] amb_sel, lit_sel, refl_sel, refl_new;
    logic                   refl_upd;
    out_t                   result;

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign m_valid = head_valid_reg;
    assign m_data  = head_reg;
    assign pop     = head_valid_reg && m_ready;

    assign is_tick = (s_data.command == CMD_TICK);
    assign sel_ok  = (s_data.sensor_select < SENSOR_IDX_W'(SENSOR_COUNT));
    assign sum     = {1'b0, s_data.sample_first} + {1'b0, s_data.sample_second};
    assign avg     = sum[SAMPLE_BITS:1];

    always_comb begin
        amb_sel  = '0;
        lit_sel  = '0;
        refl_sel = '0;
        if (sel_ok) begin
            amb_sel  = ambient_reg[s_data.sensor_select];
            lit_sel  = lit_reg[s_data.sensor_select];
            refl_sel = reflected_reg[s_data.sensor_select];
        end
        refl_upd = !is_tick && sel_ok && (amb_sel > lit_sel);
        refl_new = refl_upd ? (amb_sel - lit_sel) : refl_sel;
    end

    always_comb begin
        lit_phase_next  = lit_phase_reg;
        scan_index_next = scan_index_reg;
        if (is_tick) begin
            lit_phase_next = !lit_phase_reg;
            if (lit_phase_reg) begin
                if (scan_index_reg == SENSOR_IDX_W'(SENSOR_COUNT - 1)) begin
                    scan_index_next = '0;
                end else begin
                    scan_index_next = scan_index_reg + 1'b1;
                end
            end
        end
        result.emitter_mask    = lit_phase_next
                                 ? (SENSOR_COUNT'(1) << scan_index_next) : '0;
        result.adc_channel     = CHANNEL_W'(scan_index_next) + CHANNEL_W'(CHANNEL_OFFSET);
        result.ambient_level   = is_tick ? '0 : amb_sel;
        result.reflected_level = is_tick ? '0 : refl_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_phase_reg  <= 1'b0;
            scan_index_reg <= '0;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                ambient_reg[i]   <= '0;
                lit_reg[i]       <= '0;
                reflected_reg[i] <= '0;
            end
        end else if (push) begin
            lit_phase_reg  <= lit_phase_next;
            scan_index_reg <= scan_index_next;
            if (is_tick) begin
                if (!lit_phase_reg) begin
                    ambient_reg[scan_index_reg] <= avg;
                end else begin
                    lit_reg[scan_index_reg] <= avg;
                end
            end else if (refl_upd) begin
                reflected_reg[s_data.sensor_select] <= refl_new;
            end
        end
    end

    // two-entry output buffer: head drives m_data, skid catches a beat on stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                head_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!head_valid_reg || pop) begin
                head_reg       <= result;
                head_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= result;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            head_valid_reg <= 1'b0;
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import ipac_pkg::*;

    localparam int RANDOM_BEATS = 850;
    localparam int QUIET_TAIL   = 100;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        in_t beat;
        bit  drain;
    } pend_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    ir_proximity_ambient_cancel_scanner_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    pend_t pend_q[$];
    out_t  scan_results_q[$];

    logic                   ph_lit = 1'b0;
    int                     cur_sensor = 0;
    logic [SAMPLE_BITS-1:0] amb_mem  [SENSOR_COUNT];
    logic [SAMPLE_BITS-1:0] lit_mem  [SENSOR_COUNT];
    logic [SAMPLE_BITS-1:0] refl_mem [SENSOR_COUNT];

    int   total_beats = 0;
    int   beats_done  = 0;
    int   results_cnt = 0;
    int   err_cnt     = 0;
    int   cycle_cnt   = 0;
    int   send_gap    = 0;
    int   stall_cnt   = 0;
    bit   send_idle_on  = 1'b1;
    bit   stall_idle_on = 1'b1;
    bit   quiet;
    logic drv_valid;
    out_t want;

    assign quiet = (beats_done >= total_beats - QUIET_TAIL);

    function automatic out_t scan_predict(input in_t beat);
        out_t                 r;
        logic [SAMPLE_BITS:0] sum;
        int                   sel;
        r = '0;
        if (beat.command == CMD_TICK) begin
            sum = {1'b0, beat.sample_first} + {1'b0, beat.sample_second};
            if (!ph_lit) begin
                amb_mem[cur_sensor] = sum[SAMPLE_BITS:1];
                ph_lit = 1'b1;
            end else begin
                lit_mem[cur_sensor] = sum[SAMPLE_BITS:1];
                ph_lit = 1'b0;
                cur_sensor = (cur_sensor == SENSOR_COUNT - 1) ? 0 : cur_sensor + 1;
            end
        end else begin
            sel = int'(beat.sensor_select);
            if (sel < SENSOR_COUNT) begin
                if (amb_mem[sel] > lit_mem[sel])
                    refl_mem[sel] = amb_mem[sel] - lit_mem[sel];
                r.ambient_level   = amb_mem[sel];
                r.reflected_level = refl_mem[sel];
            end
        end
        r.emitter_mask = ph_lit ? (SENSOR_COUNT'(1) << cur_sensor) : '0;
        r.adc_channel  = CHANNEL_W'(cur_sensor + CHANNEL_OFFSET);
        return r;
    endfunction

    task automatic queue_beat(input cmd_t c, input int a, input int b, input int sel,
                              input bit drain);
        pend_t p;
        p.beat.command       = c;
        p.beat.sample_first  = SAMPLE_BITS'(a);
        p.beat.sample_second = SAMPLE_BITS'(b);
        p.beat.sensor_select = SENSOR_IDX_W'(sel);
        p.drain              = drain;
        pend_q.push_back(p);
    endtask

    task automatic tick(input int a, input int b);
        queue_beat(CMD_TICK, a, b, $urandom_range(0, 7), 1'b0);
    endtask

    task automatic read(input int sel);
        queue_beat(CMD_READ, $urandom_range(0, 4095), $urandom_range(0, 4095), sel, 1'b0);
    endtask

    task automatic note_error(input out_t exp_r, input out_t got_r, input bit orphan);
        err_cnt++;
        if (err_cnt <= 10) begin
            if (orphan)
                $display("unexpected beat: mask=%h ch=%h amb=%h refl=%h",
                         got_r.emitter_mask, got_r.adc_channel,
                         got_r.ambient_level, got_r.reflected_level);
            else
                $display({"mismatch at result %0d: exp mask=%h ch=%h amb=%h refl=%h,",
                          " got mask=%h ch=%h amb=%h refl=%h"},
                         results_cnt, exp_r.emitter_mask, exp_r.adc_channel,
                         exp_r.ambient_level, exp_r.reflected_level,
                         got_r.emitter_mask, got_r.adc_channel,
                         got_r.ambient_level, got_r.reflected_level);
        end
    endtask

    task automatic build_stimulus();
        bit gen_lit;
        int a;
        int b;
        // reads of fresh stores, including sensors that do not exist
        read(0);
        read(5);
        read(6);
        read(7);
        // sensor 0: full-scale ambient, dark lit -> large reflection
        tick(4095, 4095);
        tick(0, 0);
        read(0);
        // sensor 1: lit above ambient -> reflection held
        tick(4095, 0);
        tick(4095, 4095);
        read(1);
        // sensor 2: truncated average, equal ambient and lit
        tick(1, 0);
        tick(0, 0);
        read(2);
        // sensor 3: small positive difference
        tick(100, 101);
        tick(50, 51);
        read(3);
        tick($urandom_range(0, 4095), $urandom_range(0, 4095));
        tick($urandom_range(0, 4095), $urandom_range(0, 4095));
        // sensor 5 read mid-scan, emitter lit
        tick(3000, 2000);
        read(5);
        tick(10, 20);
        // wrap back to sensor 0, ambient now zero -> keeps old reflection
        tick(0, 0);
        read(0);

        gen_lit = 1'b0;
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 9))
                    0: begin a = 4095; b = 4095; end
                    1: begin a = 0; b = $urandom_range(0, 1); end
                    default: begin
                        a = $urandom_range(0, 4095);
                        b = $urandom_range(0, 4095);
                        if (gen_lit && $urandom_range(0, 1)) begin
                            a = a >> 1;
                            b = b >> 1;
                        end
                    end
                endcase
                queue_beat(CMD_TICK, a, b, $urandom_range(0, 7), i == RANDOM_BEATS / 2);
                gen_lit = !gen_lit;
            end else begin
                queue_beat(CMD_READ, $urandom_range(0, 4095), $urandom_range(0, 4095),
                           ($urandom_range(0, 7) == 0) ? $urandom_range(6, 7)
                                                       : $urandom_range(0, 5),
                           i == RANDOM_BEATS / 2);
            end
        end
        total_beats = pend_q.size();
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if ($urandom_range(0, 59) == 0)
                send_idle_on = !send_idle_on;
            drv_valid = s_valid;
            if (s_valid && s_ready) begin
                scan_results_q.push_back(scan_predict(s_data));
                beats_done++;
                drv_valid = 1'b0;
                if (!quiet && send_idle_on && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 4);
            end
            if (!drv_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pend_q.size() > 0 &&
                             !(pend_q[0].drain && scan_results_q.size() > 0)) begin
                    s_data    <= pend_q[0].beat;
                    drv_valid = 1'b1;
                    void'(pend_q.pop_front());
                end
            end
            s_valid <= drv_valid;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (scan_results_q.size() == 0) begin
                    note_error('0, m_data, 1'b1);
                end else begin
                    want = scan_results_q.pop_front();
                    if (m_data.emitter_mask    !== want.emitter_mask ||
                        m_data.adc_channel     !== want.adc_channel ||
                        m_data.ambient_level   !== want.ambient_level ||
                        m_data.reflected_level !== want.reflected_level)
                        note_error(want, m_data, 1'b0);
                end
                results_cnt++;
            end
            if ($urandom_range(0, 59) == 0)
                stall_idle_on = !stall_idle_on;
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else if (!quiet && stall_idle_on && $urandom_range(0, 3) == 0) begin
                stall_cnt = $urandom_range(1, 4) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("** ir_proximity_ambient_cancel_scanner_core: FAILED **");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            amb_mem[i]  = '0;
            lit_mem[i]  = '0;
            refl_mem[i] = '0;
        end
        build_stimulus();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        do
            @(posedge aclk);
        while (pend_q.size() > 0 || s_valid || scan_results_q.size() > 0);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0 && scan_results_q.size() == 0)
            $display("** ir_proximity_ambient_cancel_scanner_core: PASSED **");
        else
            $display("** ir_proximity_ambient_cancel_scanner_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ipac_pkg.sv
sv/ir_proximity_ambient_cancel_scanner_core.sv
tb/tb_top.sv
